>>> hw/rtl/btn_pkg.sv
// ----------------------------------------------------------------------------
// btn_pkg: shared types and constants
// Constants and the request type that passes from the front end to the back end.
// ----------------------------------------------------------------------------
package btn_pkg;

  localparam int YIELD_W   = 32;
  localparam int DENS_W    = 32;
  localparam int CNT_IN_W  = 16;
  localparam int TOTAL_W   = 32;
  localparam int OUT_W     = 48;
  localparam int ACC_W     = 64;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  localparam logic CFG_SIGNAL     = 1'b0;
  localparam logic CFG_BACKGROUND = 1'b1;

  // One classified bin, as handed from the front end to the back end.
  typedef struct packed {
    logic [CNT_IN_W-1:0] count;
    logic [DENS_W-1:0]   ls;
    logic [DENS_W-1:0]   lb;
    logic [YIELD_W-1:0]  sy;
    logic [YIELD_W-1:0]  by;
    logic                do_log;
    logic                last;
  } bin_req_t;

endpackage

>>> hw/rtl/btn_if.sv
// ----------------------------------------------------------------------------
// btn channel interfaces
// Valid/ready channels for bins, results and register writes.
// ----------------------------------------------------------------------------
interface btn_bin_if;
  logic        valid;
  logic        ready;
  logic [15:0] bin_count;
  logic [31:0] signal_density;
  logic [31:0] background_density;
  logic        last_bin;
  modport source(output valid, bin_count, signal_density, background_density, last_bin,
                 input ready);
  modport sink(input valid, bin_count, signal_density, background_density, last_bin,
               output ready);
endinterface

interface btn_res_if;
  logic        valid;
  logic        ready;
  logic [47:0] twice_neg_log_likelihood;
  logic [31:0] total_events;
  logic        yield_sum_zero;
  modport source(output valid, twice_neg_log_likelihood, total_events, yield_sum_zero,
                 input ready);
  modport sink(input valid, twice_neg_log_likelihood, total_events, yield_sum_zero,
               output ready);
endinterface

interface btn_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> hw/rtl/btn_front.sv
// ----------------------------------------------------------------------------
// btn_front: bin intake
// Holds yield registers, masks the count and classifies each bin into a request.
// ----------------------------------------------------------------------------
module btn_front #(
  parameter int COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  btn_bin_if.sink           bin_in,
  btn_cfg_if.sink           cfg,
  output btn_pkg::bin_req_t req,
  output logic              req_valid,
  input  logic              req_ready
);
  import btn_pkg::*;

  logic [YIELD_W-1:0]  signal_yield;
  logic [YIELD_W-1:0]  background_yield;
  logic [CNT_IN_W-1:0] cnt;
  logic [YIELD_W:0]    ysum;

  assign cfg.ready    = 1'b1;
  assign bin_in.ready = req_ready;
  assign req_valid    = bin_in.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      signal_yield     <= 32'd256;
      background_yield <= 32'd256;
    end else if (cfg.valid) begin
      if (cfg.index == CFG_SIGNAL) signal_yield <= cfg.data;
      else background_yield <= cfg.data;
    end
  end

  always_comb begin
    cnt  = bin_in.bin_count & CNT_IN_W'((64'd1 << COUNT_BITS) - 64'd1);
    ysum = {1'b0, signal_yield} + {1'b0, background_yield};
    req.count  = cnt;
    req.ls     = bin_in.signal_density;
    req.lb     = bin_in.background_density;
    req.sy     = signal_yield;
    req.by     = background_yield;
    req.last   = bin_in.last_bin;
    req.do_log = (cnt != '0) && (bin_in.signal_density != '0) &&
                 (bin_in.background_density != '0) && (ysum != '0);
  end

endmodule

>>> hw/rtl/btn_queue.sv
// ----------------------------------------------------------------------------
// btn_queue: request queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module btn_queue (
  input  logic              clk,
  input  logic              rst,
  input  btn_pkg::bin_req_t wr_req,
  input  logic              wr_valid,
  output logic              wr_ready,
  output btn_pkg::bin_req_t rd_req,
  output logic              rd_valid,
  input  logic              rd_ready
);
  import btn_pkg::*;

  bin_req_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_req   = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_req;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("queue fill out of range");
  a_pop_moves: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> fill == $past(fill) - 2'd1)
    else $error("queue fill miscount on pop");
  a_push_moves: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> fill == $past(fill) + 2'd1)
    else $error("queue fill miscount on push");
`endif

endmodule

>>> hw/rtl/btn_back.sv
// ----------------------------------------------------------------------------
// btn_back: likelihood engine
// Sequencer with a shared log2 unit, 32x32 multipliers and the accumulators.
// ----------------------------------------------------------------------------
module btn_back #(
  parameter int LOG_TABLE_BITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  btn_pkg::bin_req_t req,
  input  logic              req_valid,
  output logic              req_ready,
  btn_res_if.source         res
);
  import btn_pkg::*;

  localparam int LW = 7 + LOG_TABLE_BITS + 2;  // signed log2 width
  localparam int FC = $clog2(LOG_TABLE_BITS + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_MA, S_MB, S_SUM, S_LA, S_LA_RUN, S_LB, S_LB_RUN, S_DIFF,
    S_LN0, S_LN1, S_CM0, S_CM1, S_CM2, S_ACC,
    S_FY, S_FY_RUN, S_FLN0, S_FLN1, S_FM0, S_FM1, S_FM2, S_FIN0, S_FIN1, S_OUT
  } state_t;

  state_t state;
  bin_req_t          cur;
  logic [ACC_W-1:0]  pa;
  logic [ACC_W:0]    s65;
  logic [ACC_W-1:0]  log_sum;
  logic [TOTAL_W-1:0] event_total;
  logic [LW-1:0]     la;
  logic [LW-1:0]     dval;
  logic [ACC_W-1:0]  mag;
  logic              neg;
  logic [ACC_W-1:0]  lnv;
  logic [ACC_W-1:0]  prod;
  logic [ACC_W-1:0]  res_acc;
  logic [TOTAL_W-1:0] mcount;

  // log2 unit: one squaring per cycle
  logic [ACC_W:0]    lg_in;
  logic [6:0]        lg_p;
  logic [32:0]       lg_m;
  logic [LOG_TABLE_BITS-1:0] lg_frac;
  logic [FC-1:0]     lg_n;
  logic [6:0]        lz_p;
  logic [65:0]       sq;
  logic [63:0]       sq_sh;

  always_comb begin
    lz_p = 7'd0;
    for (int i = 1; i < 65; i++) if (lg_in[i]) lz_p = 7'(i);
  end
  assign sq    = {33'd0, lg_m} * {33'd0, lg_m};
  assign sq_sh = sq[65:2] >> 29;

  logic [63:0] lnprod;
  assign lnprod = {32'd0, mag[31:0]} * {32'd0, LN2_Q32};
  logic [63:0] mulq;
  assign mulq = {32'd0, mag[31:0]} * {32'd0, mcount};

  function automatic logic [63:0] sadd(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s;
  endfunction

  function automatic logic [63:0] sneg(input logic [63:0] a);
    return (a == {1'b1, 63'd0}) ? {1'b0, {63{1'b1}}} : (64'd0 - a);
  endfunction

  function automatic logic [OUT_W-1:0] sat48(input logic [63:0] v);
    if ($signed(v) > 64'sd140737488355327) return {1'b0, {47{1'b1}}};
    if ($signed(v) < -64'sd140737488355328) return {1'b1, 47'd0};
    return v[OUT_W-1:0];
  endfunction

  logic [LW-1:0] lg_val;
  assign lg_val = LW'({lg_p, lg_frac});
  logic [ACC_W:0] ysum;
  assign ysum = {33'd0, cur.sy} + {33'd0, cur.by};

  // event total including the incoming request, saturated
  logic [YIELD_W:0]   req_ysum;
  logic [TOTAL_W-1:0] total_next;
  assign req_ysum   = {1'b0, req.sy} + {1'b0, req.by};
  assign total_next = ({1'b0, event_total} + {17'd0, req.count} > 33'hFFFFFFFF)
                      ? '1 : event_total + {16'd0, req.count};

  assign req_ready = (state == S_IDLE) && !res.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      log_sum     <= '0;
      event_total <= '0;
      res.valid   <= 1'b0;
    end else begin
      if (res.valid && res.ready) res.valid <= 1'b0;
      unique case (state)
        S_IDLE: if (req_valid && req_ready) begin
          cur <= req;
          if (req.last && req_ysum == '0) begin
            // zero yield sum: flag the result and skip the final term
            res.valid <= 1'b1;
            res.twice_neg_log_likelihood <= '0;
            res.yield_sum_zero <= 1'b1;
            res.total_events <= total_next;
            log_sum <= '0;
            event_total <= '0;
            state <= S_IDLE;
          end else begin
            event_total <= total_next;
            state <= req.do_log ? S_MA : (req.last ? S_FY : S_IDLE);
          end
        end
        S_MA: begin
          pa <= {32'd0, cur.sy} * {32'd0, cur.ls};
          state <= S_MB;
        end
        S_MB: begin
          prod <= {32'd0, cur.by} * {32'd0, cur.lb};
          state <= S_SUM;
        end
        S_SUM: begin
          s65 <= {1'b0, pa} + {1'b0, prod};
          state <= S_LA;
        end
        S_LA: begin
          lg_in <= s65;
          state <= S_LA_RUN;
          lg_n  <= '0;
        end
        S_LB, S_FY: begin
          // hold the first log2 result while the unit runs again
          if (state == S_LB) la <= lg_val;
          lg_in <= ysum;
          lg_n  <= '0;
          state <= (state == S_LB) ? S_LB_RUN : S_FY_RUN;
        end
        S_LA_RUN, S_LB_RUN, S_FY_RUN: begin
          if (lg_n == '0) begin
            lg_p <= lz_p;
            lg_m <= (lz_p >= 7'd31) ? 33'(lg_in >> (lz_p - 7'd31))
                                    : 33'(lg_in << (7'd31 - lz_p));
            lg_frac <= '0;
            lg_n <= lg_n + 1'b1;
          end else begin
            lg_frac <= {lg_frac[LOG_TABLE_BITS-2:0], sq_sh[32]};
            lg_m <= sq_sh[32] ? sq_sh[33:1] : sq_sh[32:0];
            if (lg_n == FC'(LOG_TABLE_BITS)) begin
              unique case (state)
                S_LA_RUN: state <= S_LB;
                S_LB_RUN: state <= S_DIFF;
                default:  state <= S_FLN0;
              endcase
            end else lg_n <= lg_n + 1'b1;
          end
        end
        S_DIFF: begin
          dval  <= la - lg_val - LW'(32 << LOG_TABLE_BITS);
          state <= S_LN0;
        end
        S_LN0: begin
          neg   <= dval[LW-1];
          mag   <= dval[LW-1] ? ACC_W'(-$signed(dval)) : ACC_W'(dval);
          state <= S_LN1;
        end
        S_LN1, S_FLN1: begin
          mag    <= ACC_W'(lnprod >> (LOG_TABLE_BITS + 16));
          mcount <= (state == S_LN1) ? TOTAL_W'(cur.count) : event_total;
          state  <= (state == S_LN1) ? S_CM0 : S_FM0;
        end
        S_CM0, S_FM0: begin
          prod  <= mulq;
          state <= (state == S_CM0) ? S_CM1 : S_FM1;
        end
        S_CM1, S_FM1: begin
          lnv   <= neg ? 64'd0 - prod : prod;
          state <= (state == S_CM1) ? S_ACC : S_FIN0;
        end
        S_ACC: begin
          log_sum <= sadd(log_sum, lnv);
          state   <= cur.last ? S_FY : S_IDLE;
        end
        S_FLN0: begin
          neg   <= lg_val < LW'(8 << LOG_TABLE_BITS);
          mag   <= (lg_val < LW'(8 << LOG_TABLE_BITS))
                   ? ACC_W'(LW'(8 << LOG_TABLE_BITS) - lg_val)
                   : ACC_W'(lg_val - LW'(8 << LOG_TABLE_BITS));
          state <= S_FLN1;
        end
        S_FIN0: begin
          res_acc <= sadd(sneg(log_sum), {ysum[55:0], 8'd0});
          state   <= S_FIN1;
        end
        S_FIN1: begin
          res_acc <= sadd(res_acc, sneg(lnv));
          state   <= S_OUT;
        end
        S_OUT: begin
          res.valid <= 1'b1;
          res.yield_sum_zero <= 1'b0;
          res.total_events <= event_total;
          res.twice_neg_log_likelihood <= sat48(sadd(res_acc, res_acc));
          log_sum <= '0;
          event_total <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> state == S_IDLE)
    else $error("request taken outside idle");
  a_out_clears: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |=> log_sum == '0 && event_total == '0)
    else $error("accumulators not cleared after result");
  a_res_once: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> state == S_IDLE)
    else $error("result raised mid-bin");
`endif

endmodule

>>> hw/rtl/binned_template_nll.sv
// ----------------------------------------------------------------------------
// binned_template_nll: two-template extended binned likelihood
// Streams histogram bins and emits twice the negative log likelihood on the last.
//
//   channel  | dir | payload
//   bin_in   | in  | bin_count, signal_density, background_density, last_bin
//   res_out  | out | twice_neg_log_likelihood, total_events, yield_sum_zero
//   cfg      | in  | index, data (0 signal_yield, 1 background_yield)
//
// A bin with no log term returns the back end straight to idle unless it is last.
// A log bin forms the mixture (S_MA, S_MB, S_SUM), runs log2 on it and on the
// yield sum, then scales and accumulates (S_DIFF to S_ACC). The queue sits in front.
// The last bin then runs log2 on the yield sum and forms the result (S_FY to S_OUT).
// Reset is synchronous; yields return to 1.0 and the accumulators to zero.
// A held result blocks new bins until it is taken.
// ----------------------------------------------------------------------------
module binned_template_nll #(
  parameter int COUNT_BITS     = 16,
  parameter int LOG_TABLE_BITS = 8
) (
  input logic     clk,
  input logic     rst,
  btn_bin_if.sink bin_in,
  btn_res_if.source res_out,
  btn_cfg_if.sink cfg
);
  import btn_pkg::*;

  bin_req_t f_req;
  bin_req_t q_req;
  logic     f_valid;
  logic     f_ready;
  logic     q_valid;
  logic     q_ready;

  btn_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk, .rst, .bin_in, .cfg,
    .req(f_req), .req_valid(f_valid), .req_ready(f_ready)
  );

  btn_queue u_queue (
    .clk, .rst,
    .wr_req(f_req), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_req(q_req), .rd_valid(q_valid), .rd_ready(q_ready)
  );

  btn_back #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_back (
    .clk, .rst,
    .req(q_req), .req_valid(q_valid), .req_ready(q_ready),
    .res(res_out)
  );

endmodule
